// ----- sv/mbt_pkg.sv -----
// Shared constants, types and sequencer states of the Mandelbrot escape-time block.
package mbt_pkg;

  localparam int DIM_BITS   = 12;
  localparam int FRAC_BITS  = 28;
  localparam int WORD_W     = FRAC_BITS + 4;
  localparam int SIZE_W     = DIM_BITS + 1;
  localparam int ITER_W     = 16;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int SQ_W       = PROD_W - FRAC_BITS;
  localparam int DIV_STEPS  = SIZE_W + FRAC_BITS;
  localparam int STEP_W     = $clog2(DIV_STEPS);
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 16;

  typedef logic [WORD_W-1:0] word_t;
  typedef logic signed [WORD_W-1:0] fx_t;
  typedef logic signed [PROD_W-1:0] prod_t;

  localparam word_t FX_ONE    = word_t'(1) << FRAC_BITS;
  localparam word_t RE_OFFSET = FX_ONE + (FX_ONE >> 1);
  localparam word_t IM_OFFSET = FX_ONE;
  localparam logic [SQ_W:0] ESC_LIMIT = (SQ_W + 1)'(1) << (FRAC_BITS + 2);

  localparam logic [SIZE_W-1:0] WIDTH_RST    = SIZE_W'(640);
  localparam logic [SIZE_W-1:0] HEIGHT_RST   = SIZE_W'(480);
  localparam logic [ITER_W-1:0] MAX_ITER_RST = ITER_W'(256);

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH    = 2'd0,
    CFG_HEIGHT   = 2'd1,
    CFG_MAX_ITER = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV_RE,
    ST_DIV_IM,
    ST_MUL_XX,
    ST_MUL_YY,
    ST_TEST,
    ST_UPDATE,
    ST_DONE
  } state_t;

endpackage

// ----- sv/mbt_ifs.sv -----
// Request and result channel interfaces of the Mandelbrot escape-time block.
interface mbt_in_if;
  import mbt_pkg::*;
  logic                valid;
  logic                ready;
  logic [DIM_BITS-1:0] pixel_row;
  logic [DIM_BITS-1:0] pixel_column;

  modport source (output valid, output pixel_row, output pixel_column, input ready);
  modport sink (input valid, input pixel_row, input pixel_column, output ready);
endinterface

interface mbt_out_if;
  import mbt_pkg::*;
  logic              valid;
  logic              ready;
  logic              inside_res;
  logic [ITER_W-1:0] iteration_count;

  modport source (output valid, output inside_res, output iteration_count, input ready);
  modport sink (input valid, input inside_res, input iteration_count, output ready);
endinterface

// ----- sv/mandelbrot_escape_time.sv -----
// Mandelbrot escape-time pixel evaluator with a shared divider step and multiplier.
//
//   channel  | dir | handshake          | payload
//   in_px    | in  | valid / ready      | pixel_row[11:0], pixel_column[11:0]
//   out_res  | out | valid / ready      | inside_res, iteration_count[15:0]
//   cfg      | in  | cfg_wr_en          | cfg_index[1:0], cfg_wdata[15:0]
//
// Each pixel runs two 41-step restoring divisions that give c, then iterates through the
// multiplier states MUL_XX, MUL_YY and TEST and an UPDATE state, the last iteration
// without the update.
// Synchronous active-low reset clears the sequencer and loads the register defaults.
// A new request is taken as soon as the previous result sits in the output register;
// a stalled result holds the sequencer in its final state until the register frees.
module mandelbrot_escape_time (
  input  logic                           clk,
  input  logic                           rst_n,
  mbt_in_if.sink                         in_px,
  mbt_out_if.source                      out_res,
  input  logic                           cfg_wr_en,
  input  logic [mbt_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [mbt_pkg::CFG_DATA_W-1:0] cfg_wdata
);
  import mbt_pkg::*;

  state_t              state_r, state_nxt;
  logic [SIZE_W-1:0]   width_r, height_r;
  logic [ITER_W-1:0]   max_iter_r;

  logic [DIM_BITS-1:0] row_r;
  logic [SIZE_W-1:0]   num_r, rem_r, rem_nxt, div_size;
  logic [SIZE_W:0]     trial;
  logic                fits;
  logic [STEP_W-1:0]   step_r;
  word_t               quo_r, quo_nxt;
  logic                div_last;

  word_t               c_re_r, c_im_r;
  fx_t                 x_r, y_r, mul_a, mul_b;
  prod_t               prod_r;
  logic [SQ_W-1:0]     sx_r, sq_y;
  word_t               sy_r;
  logic [SQ_W:0]       esc_sum;
  logic                escape, limit_hit;
  logic [ITER_W-1:0]   n_r, iter_inc;

  logic                out_valid_r, inside_r, out_load;
  logic [ITER_W-1:0]   count_r;
  logic                in_acc;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      width_r    <= WIDTH_RST;
      height_r   <= HEIGHT_RST;
      max_iter_r <= MAX_ITER_RST;
    end else if (cfg_wr_en) begin
      case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:    width_r    <= cfg_wdata[SIZE_W-1:0];
        CFG_HEIGHT:   height_r   <= cfg_wdata[SIZE_W-1:0];
        CFG_MAX_ITER: max_iter_r <= cfg_wdata[ITER_W-1:0];
        default: ;
      endcase
    end
  end

  // Divider step: a size of zero divides as one.
  always_comb begin
    div_size = (state_r == ST_DIV_IM) ? height_r : width_r;
    if (div_size == '0) begin
      div_size = SIZE_W'(1);
    end
    trial    = {rem_r, num_r[SIZE_W-1]};
    fits     = trial >= {1'b0, div_size};
    rem_nxt  = fits ? SIZE_W'(trial - {1'b0, div_size}) : trial[SIZE_W-1:0];
    quo_nxt  = {quo_r[WORD_W-2:0], fits};
    div_last = step_r == STEP_W'(DIV_STEPS - 1);
  end

  // Escape test and counter.
  always_comb begin
    sq_y      = prod_r[PROD_W-1:FRAC_BITS];
    esc_sum   = {1'b0, sx_r} + {1'b0, sq_y};
    escape    = esc_sum >= ESC_LIMIT;
    iter_inc  = n_r + ITER_W'(1);
    limit_hit = iter_inc >= max_iter_r;
  end

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE:   if (in_px.valid) state_nxt = ST_DIV_RE;
      ST_DIV_RE: if (div_last) state_nxt = ST_DIV_IM;
      ST_DIV_IM: if (div_last) state_nxt = ST_MUL_XX;
      ST_MUL_XX: state_nxt = ST_MUL_YY;
      ST_MUL_YY: state_nxt = ST_TEST;
      ST_TEST:   state_nxt = (escape || limit_hit) ? ST_DONE : ST_UPDATE;
      ST_UPDATE: state_nxt = ST_MUL_XX;
      ST_DONE:   if (!out_valid_r || out_res.ready) state_nxt = ST_IDLE;
      default:   state_nxt = ST_IDLE;
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    in_px.ready = 1'b0;
    out_load    = 1'b0;
    mul_a       = x_r;
    mul_b       = x_r;
    case (state_r)
      ST_IDLE: in_px.ready = 1'b1;
      ST_MUL_YY: begin
        mul_a = y_r;
        mul_b = y_r;
      end
      ST_TEST: mul_b = y_r;
      ST_DONE: out_load = !out_valid_r || out_res.ready;
      default: ;
    endcase
  end

  assign in_acc = in_px.valid && in_px.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_res.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath.
  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
    case (state_r)
      ST_IDLE: begin
        row_r  <= in_px.pixel_row;
        num_r  <= {in_px.pixel_column, 1'b0};
        rem_r  <= '0;
        quo_r  <= '0;
        step_r <= '0;
      end
      ST_DIV_RE, ST_DIV_IM: begin
        rem_r  <= rem_nxt;
        quo_r  <= quo_nxt;
        num_r  <= num_r << 1;
        step_r <= step_r + STEP_W'(1);
        if (div_last) begin
          rem_r  <= '0;
          step_r <= '0;
          num_r  <= {row_r, 1'b0};
          if (state_r == ST_DIV_RE) begin
            c_re_r <= quo_nxt - RE_OFFSET;
          end else begin
            c_im_r <= quo_nxt - IM_OFFSET;
            x_r    <= '0;
            y_r    <= '0;
            n_r    <= '0;
          end
        end
      end
      ST_MUL_YY: sx_r <= prod_r[PROD_W-1:FRAC_BITS];
      ST_TEST: begin
        sy_r <= sq_y[WORD_W-1:0];
        if (!escape) begin
          n_r <= iter_inc;
        end
      end
      ST_UPDATE: begin
        // The product now holds x*y; taking it one bit lower doubles it.
        x_r <= fx_t'(sx_r[WORD_W-1:0] - sy_r + c_re_r);
        y_r <= fx_t'(prod_r[WORD_W+FRAC_BITS-2:FRAC_BITS-1] + c_im_r);
      end
      ST_DONE: begin
        if (out_load) begin
          inside_r <= n_r == max_iter_r;
          count_r  <= n_r;
        end
      end
      default: ;
    endcase
  end

  assign out_res.valid           = out_valid_r;
  assign out_res.inside_res      = inside_r;
  assign out_res.iteration_count = count_r;

  // The counter never runs past the limit, or past one when the limit is zero.
  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST || state_r == ST_DONE) |-> (n_r <= max_iter_r || n_r == ITER_W'(1)))
    else $error("iteration counter exceeded its limit");

  // An inside result always carries the limit as its count.
  a_inside_count: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && inside_r) |-> (count_r == max_iter_r))
    else $error("inside flag without a full count");

  // A new request starts the real-part division from its first step.
  a_start_div: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> (state_r == ST_DIV_RE && step_r == '0))
    else $error("request did not start the divider");

  // Every further iteration is counted exactly once.
  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_TEST && state_nxt == ST_UPDATE) |=> (n_r == $past(n_r) + ITER_W'(1)))
    else $error("iteration count did not advance");

endmodule
